FILE: hdl/svg_pkg.sv
`default_nettype none
package svg_pkg;

  localparam int MAX_STEPS_DEF     = 1024;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam int STEP_W  = 11;
  localparam int IDX_W   = 10;
  localparam int RAD_W   = 16;
  localparam int POS_W   = 17;
  localparam int NRM_W   = 16;
  localparam int PHASE_W = 32;
  localparam int TRIG_W  = 32;
  // CORDIC datapath carries one guard bit above the Q30 trig range
  localparam int CW      = 33;

  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = PHASE_W / DIV_BITS;

  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [CW-1:0] QUARTER_TURN    = 33'sd1073741824;
  localparam logic signed [CW-1:0] HALF_TURN       = 33'sd2147483648;

  localparam logic [PHASE_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [1:0] {
    REG_RADIUS    = 2'd0,
    REG_LAT_STEPS = 2'd1,
    REG_LON_STEPS = 2'd2
  } cfg_reg_t;

endpackage
`default_nettype wire

FILE: hdl/svg_div.sv
`default_nettype none
module svg_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [svg_pkg::STEP_W-1:0]  hi,
  input  wire logic [svg_pkg::PHASE_W-1:0] lo,
  input  wire logic [svg_pkg::STEP_W-1:0]  den,
  output      logic [svg_pkg::PHASE_W-1:0] quo
);

  logic [svg_pkg::STEP_W-1:0]  rem_r  [svg_pkg::DIV_STAGES];
  logic [svg_pkg::PHASE_W-1:0] word_r [svg_pkg::DIV_STAGES];

  // Restoring division: dividend bits shift out of the top of word while
  // quotient bits shift in at the bottom.
  for (genvar s = 0; s < svg_pkg::DIV_STAGES; s++) begin : g_stage
    logic [svg_pkg::STEP_W-1:0]  rem_in;
    logic [svg_pkg::STEP_W-1:0]  rem_nxt;
    logic [svg_pkg::PHASE_W-1:0] word_in;
    logic [svg_pkg::PHASE_W-1:0] word_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = hi;
      assign word_in = lo;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign word_in = word_r[s-1];
    end

    always_comb begin
      logic [svg_pkg::STEP_W:0] trial;
      rem_nxt  = rem_in;
      word_nxt = word_in;
      trial    = '0;
      for (int b = 0; b < svg_pkg::DIV_BITS; b++) begin
        trial    = {rem_nxt, word_nxt[svg_pkg::PHASE_W-1]};
        word_nxt = {word_nxt[svg_pkg::PHASE_W-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          trial       = trial - {1'b0, den};
          word_nxt[0] = 1'b1;
        end
        rem_nxt = trial[svg_pkg::STEP_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        word_r[s] <= word_nxt;
      end
    end
  end

  assign quo = word_r[svg_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: hdl/svg_cordic.sv
`default_nettype none
module svg_cordic #(
  parameter int N_IT = svg_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic        [svg_pkg::PHASE_W-1:0] phase,
  output      logic signed [svg_pkg::TRIG_W-1:0]  cos_o,
  output      logic signed [svg_pkg::TRIG_W-1:0]  sin_o
);

  logic signed [svg_pkg::CW-1:0] x_r [N_IT+1];
  logic signed [svg_pkg::CW-1:0] y_r [N_IT+1];
  logic signed [svg_pkg::CW-1:0] z_r [N_IT+1];
  logic                          flip_r [N_IT+1];
  logic signed [svg_pkg::TRIG_W-1:0] cos_r;
  logic signed [svg_pkg::TRIG_W-1:0] sin_r;

  logic signed [svg_pkg::CW-1:0] z0_nxt;
  logic                          flip_nxt;

  // fold the phase to within a quarter turn, flipping signs on a half turn
  always_comb begin
    logic signed [svg_pkg::CW-1:0] zs;
    zs       = {phase[svg_pkg::PHASE_W-1], phase};
    z0_nxt   = zs;
    flip_nxt = 1'b0;
    if (zs >= svg_pkg::QUARTER_TURN) begin
      z0_nxt   = zs - svg_pkg::HALF_TURN;
      flip_nxt = 1'b1;
    end else if (zs < -svg_pkg::QUARTER_TURN) begin
      z0_nxt   = zs + svg_pkg::HALF_TURN;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= svg_pkg::CORDIC_GAIN_Q30;
      y_r[0]    <= '0;
      z_r[0]    <= z0_nxt;
      flip_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < N_IT; i++) begin : g_iter
    logic signed [svg_pkg::CW-1:0] x_nxt;
    logic signed [svg_pkg::CW-1:0] y_nxt;
    logic signed [svg_pkg::CW-1:0] z_nxt;

    always_comb begin
      logic signed [svg_pkg::CW-1:0] xs;
      logic signed [svg_pkg::CW-1:0] ys;
      logic signed [svg_pkg::CW-1:0] ang;
      xs  = x_r[i] >>> i;
      ys  = y_r[i] >>> i;
      ang = signed'({1'b0, svg_pkg::ATAN_TABLE[i]});
      if (!z_r[i][svg_pkg::CW-1]) begin
        x_nxt = x_r[i] - ys;
        y_nxt = y_r[i] + xs;
        z_nxt = z_r[i] - ang;
      end else begin
        x_nxt = x_r[i] + ys;
        y_nxt = y_r[i] - xs;
        z_nxt = z_r[i] + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (flip_r[N_IT]) begin
        cos_r <= svg_pkg::TRIG_W'(-x_r[N_IT]);
        sin_r <= svg_pkg::TRIG_W'(-y_r[N_IT]);
      end else begin
        cos_r <= svg_pkg::TRIG_W'(x_r[N_IT]);
        sin_r <= svg_pkg::TRIG_W'(y_r[N_IT]);
      end
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
`default_nettype wire

FILE: hdl/svg_out.sv
`default_nettype none
module svg_out (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic                             err_i,
  input  wire logic        [svg_pkg::RAD_W-1:0]  radius,
  input  wire logic signed [svg_pkg::TRIG_W-1:0] ct,
  input  wire logic signed [svg_pkg::TRIG_W-1:0] st,
  input  wire logic signed [svg_pkg::TRIG_W-1:0] cp,
  input  wire logic signed [svg_pkg::TRIG_W-1:0] sp,
  output      logic signed [svg_pkg::POS_W-1:0]  pos_x,
  output      logic signed [svg_pkg::POS_W-1:0]  pos_y,
  output      logic signed [svg_pkg::POS_W-1:0]  pos_z,
  output      logic signed [svg_pkg::NRM_W-1:0]  nrm_x,
  output      logic signed [svg_pkg::NRM_W-1:0]  nrm_y,
  output      logic signed [svg_pkg::NRM_W-1:0]  nrm_z
);

  localparam int PW = 2 * svg_pkg::TRIG_W;
  localparam int MW = svg_pkg::RAD_W + 1 + svg_pkg::CW;

  logic signed [PW-1:0]             pc_r, ps_r;
  logic signed [svg_pkg::TRIG_W-1:0] ct_r;
  logic signed [svg_pkg::CW-1:0]     d_r    [3];
  logic signed [MW-1:0]             prod_r [3];
  logic signed [svg_pkg::NRM_W-1:0]  nrm_r  [3];
  logic signed [svg_pkg::POS_W-1:0]  pos2_r [3];
  logic signed [svg_pkg::NRM_W-1:0]  nrm2_r [3];

  logic signed [svg_pkg::CW-1:0]     d_nxt    [3];
  logic signed [MW-1:0]             prod_nxt [3];
  logic signed [svg_pkg::NRM_W-1:0]  nrm_nxt  [3];
  logic signed [svg_pkg::POS_W-1:0]  pos_nxt  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r <= cp * st;
      ps_r <= sp * st;
      ct_r <= ct;
    end
  end

  always_comb begin
    logic signed [PW-1:0] rc;
    logic signed [PW-1:0] rs;
    rc       = (pc_r + PW'(64'sd536870912)) >>> 30;
    rs       = (ps_r + PW'(64'sd536870912)) >>> 30;
    d_nxt[0] = svg_pkg::CW'(rc);
    d_nxt[1] = svg_pkg::CW'(rs);
    d_nxt[2] = {ct_r[svg_pkg::TRIG_W-1], ct_r};
  end

  always_comb begin
    logic signed [svg_pkg::CW:0] nv;
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = signed'({1'b0, radius}) * d_r[k];
      nv = (-signed'({d_r[k][svg_pkg::CW-1], d_r[k]}) + 34'sd16384) >>> 15;
      if (nv > 34'sd32767) begin
        nrm_nxt[k] = 16'sd32767;
      end else if (nv < -34'sd32767) begin
        nrm_nxt[k] = -16'sd32767;
      end else begin
        nrm_nxt[k] = svg_pkg::NRM_W'(nv);
      end
    end
  end

  always_comb begin
    logic signed [MW-1:0] pv;
    for (int k = 0; k < 3; k++) begin
      pv = (prod_r[k] + MW'(50'sd536870912)) >>> 30;
      if (err_i) begin
        pos_nxt[k] = '0;
      end else if (pv > MW'(50'sd65535)) begin
        pos_nxt[k] = 17'sd65535;
      end else if (pv < -MW'(50'sd65535)) begin
        pos_nxt[k] = -17'sd65535;
      end else begin
        pos_nxt[k] = svg_pkg::POS_W'(pv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_r[k]    <= d_nxt[k];
        prod_r[k] <= prod_nxt[k];
        nrm_r[k]  <= nrm_nxt[k];
        pos2_r[k] <= pos_nxt[k];
        nrm2_r[k] <= err_i ? '0 : nrm_r[k];
      end
    end
  end

  assign pos_x = pos2_r[0];
  assign pos_y = pos2_r[1];
  assign pos_z = pos2_r[2];
  assign nrm_x = nrm2_r[0];
  assign nrm_y = nrm2_r[1];
  assign nrm_z = nrm2_r[2];

endmodule
`default_nettype wire

FILE: hdl/sphere_vertex_generator.sv
`default_nettype none
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid / in_ready   | in_lat_index, in_lon_index
// out      | out_valid / out_ready | out_pos_x/y/z, out_normal_x/y/z,
//          |                       | out_index_error
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One vertex per clock while the output is not stalled. The pipeline is an input
// stage, a 16-stage divider retiring two quotient bits per stage, the CORDIC
// (fold, one stage per iteration, sign stage) and four multiply/round stages.
// Synchronous active-low reset clears valid bits and restores the registers.
// A stalled output word freezes the whole pipeline; both ready outputs are low
// during reset and cfg_ready is high otherwise.
module sphere_vertex_generator #(
  parameter int MAX_STEPS     = svg_pkg::MAX_STEPS_DEF,
  parameter int CORDIC_STAGES = svg_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic        [svg_pkg::IDX_W-1:0]  in_lat_index,
  input  wire logic        [svg_pkg::IDX_W-1:0]  in_lon_index,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic signed [svg_pkg::POS_W-1:0]  out_pos_x,
  output      logic signed [svg_pkg::POS_W-1:0]  out_pos_y,
  output      logic signed [svg_pkg::POS_W-1:0]  out_pos_z,
  output      logic signed [svg_pkg::NRM_W-1:0]  out_normal_x,
  output      logic signed [svg_pkg::NRM_W-1:0]  out_normal_y,
  output      logic signed [svg_pkg::NRM_W-1:0]  out_normal_z,
  output      logic                             out_index_error,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic        [1:0]                cfg_index,
  input  wire logic        [svg_pkg::RAD_W-1:0]  cfg_data
);

  localparam int N_IT = (CORDIC_STAGES > svg_pkg::ATAN_ENTRIES) ?
                        svg_pkg::ATAN_ENTRIES : CORDIC_STAGES;
  localparam int STEP_MAXV = (1 << svg_pkg::STEP_W) - 1;
  localparam int STEP_CAP  = (MAX_STEPS > STEP_MAXV) ? STEP_MAXV : MAX_STEPS;
  localparam int LAT = 1 + svg_pkg::DIV_STAGES + N_IT + 2 + 4;

  logic [svg_pkg::RAD_W-1:0]  radius_r;
  logic [svg_pkg::STEP_W-1:0] lat_steps_r;
  logic [svg_pkg::STEP_W-1:0] lon_steps_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= svg_pkg::RAD_W'(16);
      lat_steps_r <= svg_pkg::STEP_W'(16);
      lon_steps_r <= svg_pkg::STEP_W'(32);
    end else if (cfg_valid) begin
      unique case (svg_pkg::cfg_reg_t'(cfg_index))
        svg_pkg::REG_RADIUS:    radius_r    <= cfg_data;
        svg_pkg::REG_LAT_STEPS: lat_steps_r <= cfg_data[svg_pkg::STEP_W-1:0];
        svg_pkg::REG_LON_STEPS: lon_steps_r <= cfg_data[svg_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [svg_pkg::STEP_W-1:0] ls, ns;
  assign ls = (lat_steps_r > svg_pkg::STEP_W'(STEP_CAP)) ?
              svg_pkg::STEP_W'(STEP_CAP) : lat_steps_r;
  assign ns = (lon_steps_r > svg_pkg::STEP_W'(STEP_CAP)) ?
              svg_pkg::STEP_W'(STEP_CAP) : lon_steps_r;

  logic en;
  logic [LAT-1:0] v_r;
  logic [LAT-1:0] err_r;
  logic [svg_pkg::IDX_W-1:0] lat_r, lon_r;
  logic err_in;

  // advance everything unless a finished word is held at the output
  assign en       = out_ready || !v_r[LAT-1];
  assign in_ready = en && rst_n;
  assign err_in   = ({1'b0, in_lat_index} >= ls) || ({1'b0, in_lon_index} >= ns);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_r <= {err_r[LAT-2:0], err_in};
      lat_r <= in_lat_index;
      lon_r <= in_lon_index;
    end
  end

  // theta: (lat * 2^31 + ls/2) / ls ; phi: (lon * 2^32 + ns/2) / ns
  logic [svg_pkg::STEP_W-1:0]  th_hi, ph_hi;
  logic [svg_pkg::PHASE_W-1:0] th_lo, ph_lo;
  logic [svg_pkg::PHASE_W-1:0] th_phase, ph_phase;

  assign th_hi = {2'b00, lat_r[svg_pkg::IDX_W-1:1]};
  assign th_lo = {lat_r[0], 21'd0, ls[svg_pkg::STEP_W-1:1]};
  assign ph_hi = {1'b0, lon_r};
  assign ph_lo = {22'd0, ns[svg_pkg::STEP_W-1:1]};

  svg_div u_div_theta (
    .clk (clk), .en (en), .hi (th_hi), .lo (th_lo), .den (ls), .quo (th_phase)
  );

  svg_div u_div_phi (
    .clk (clk), .en (en), .hi (ph_hi), .lo (ph_lo), .den (ns), .quo (ph_phase)
  );

  logic signed [svg_pkg::TRIG_W-1:0] ct, st, cp, sp;

  svg_cordic #(.N_IT(N_IT)) u_cordic_theta (
    .clk (clk), .en (en), .phase (th_phase), .cos_o (ct), .sin_o (st)
  );

  svg_cordic #(.N_IT(N_IT)) u_cordic_phi (
    .clk (clk), .en (en), .phase (ph_phase), .cos_o (cp), .sin_o (sp)
  );

  svg_out u_out (
    .clk    (clk),
    .en     (en),
    .err_i  (err_r[LAT-2]),
    .radius (radius_r),
    .ct     (ct),
    .st     (st),
    .cp     (cp),
    .sp     (sp),
    .pos_x  (out_pos_x),
    .pos_y  (out_pos_y),
    .pos_z  (out_pos_z),
    .nrm_x  (out_normal_x),
    .nrm_y  (out_normal_y),
    .nrm_z  (out_normal_z)
  );

  assign out_valid       = v_r[LAT-1];
  assign out_index_error = err_r[LAT-1];

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |->
      out_pos_x == '0 && out_pos_y == '0 && out_pos_z == '0 &&
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("index error word carries nonzero payload");

  a_nrm_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_normal_x != 16'sh8000 && out_normal_y != 16'sh8000 &&
      out_normal_z != 16'sh8000)
    else $error("normal escaped saturation");

  a_cfg_lat: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == 2'(svg_pkg::REG_LAT_STEPS) |=>
      lat_steps_r == $past(cfg_data[svg_pkg::STEP_W-1:0]))
    else $error("lat_steps write lost");
`endif

endmodule
`default_nettype wire

FILE: dv/sphere_vertex_generator_test.sv
module sphere_vertex_generator_test;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int PIPE_DRAIN = 60;

  typedef struct {
    logic signed [svg_pkg::POS_W-1:0] px, py, pz;
    logic signed [svg_pkg::NRM_W-1:0] nx, ny, nz;
    logic                             err;
  } vertex_t;

  typedef struct {
    logic [svg_pkg::IDX_W-1:0] lat, lon;
  } step_pair_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [svg_pkg::IDX_W-1:0] in_lat_index, in_lon_index;
  logic out_valid, out_ready;
  logic signed [svg_pkg::POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [svg_pkg::NRM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_index_error;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [svg_pkg::RAD_W-1:0] cfg_data;

  sphere_vertex_generator uut (.*);

  // shadow copy of the block's registers
  longint radius_sh, lat_steps_sh, lon_steps_sh;

  step_pair_t pending_steps[$];
  vertex_t    vertex_fifo[$];
  step_pair_t next_pair;
  int tx_idle, rx_idle;
  int errors, sent_words, got_words, err_words;
  bit hold_off;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic longint clamp_steps(longint s);
    return (s > svg_pkg::MAX_STEPS_DEF) ? svg_pkg::MAX_STEPS_DEF : s;
  endfunction

  function automatic longint round_down(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void sin_cos_q30(input longint phase, output longint c,
                                      output longint s);
    longint z, x, y, t, xs, ys;
    bit flip;
    int n;
    z = phase & 64'hFFFF_FFFF;
    x = svg_pkg::CORDIC_GAIN_Q30;
    y = 0;
    flip = 0;
    n = (svg_pkg::CORDIC_STAGES_DEF > svg_pkg::ATAN_ENTRIES) ?
        svg_pkg::ATAN_ENTRIES : svg_pkg::CORDIC_STAGES_DEF;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    // fold into a quarter turn around zero, flipping the sign
    if (z >= 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        t = x - ys; y = y + xs; z -= longint'(svg_pkg::ATAN_TABLE[i]);
      end else begin
        t = x + ys; y = y - xs; z += longint'(svg_pkg::ATAN_TABLE[i]);
      end
      x = t;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic vertex_t sphere_point(logic [svg_pkg::IDX_W-1:0] lat,
                                           logic [svg_pkg::IDX_W-1:0] lon);
    vertex_t v;
    longint ls, ns, ct, st, cp, sp, d[3], p[3], nr[3];
    ls = clamp_steps(lat_steps_sh);
    ns = clamp_steps(lon_steps_sh);
    v = '{default: 0};
    if (lat >= ls || lon >= ns) begin
      v.err = 1;
      return v;
    end
    sin_cos_q30(((longint'(lat) << 31) + ls / 2) / ls, ct, st);
    sin_cos_q30(((longint'(lon) << 32) + ns / 2) / ns, cp, sp);
    d[0] = round_down(cp * st, 30);
    d[1] = round_down(sp * st, 30);
    d[2] = ct;
    for (int k = 0; k < 3; k++) begin
      p[k] = sat(round_down(radius_sh * d[k], 30), 65535);
      nr[k] = sat(round_down(-d[k], 15), 32767);
    end
    v.px = svg_pkg::POS_W'(p[0]);
    v.py = svg_pkg::POS_W'(p[1]);
    v.pz = svg_pkg::POS_W'(p[2]);
    v.nx = svg_pkg::NRM_W'(nr[0]);
    v.ny = svg_pkg::NRM_W'(nr[1]);
    v.nz = svg_pkg::NRM_W'(nr[2]);
    return v;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("mismatch on word %0d: %s got %0d expected %0d", got_words, field, got, want);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready) begin
        vertex_fifo.push_back(sphere_point(in_lat_index, in_lon_index));
        sent_words++;
      end
      if (!in_valid || in_ready) begin
        if (pending_steps.size() > 0 && $urandom_range(99) >= tx_idle) begin
          next_pair = pending_steps.pop_front();
          in_valid <= 1;
          in_lat_index <= next_pair.lat;
          in_lon_index <= next_pair.lon;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin
    vertex_t w;
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= rx_idle);
      if (out_valid && out_ready) begin
        got_words++;
        if (vertex_fifo.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          w = vertex_fifo.pop_front();
          if (out_pos_x != w.px) report_mismatch("pos_x", out_pos_x, w.px);
          if (out_pos_y != w.py) report_mismatch("pos_y", out_pos_y, w.py);
          if (out_pos_z != w.pz) report_mismatch("pos_z", out_pos_z, w.pz);
          if (out_normal_x != w.nx) report_mismatch("normal_x", out_normal_x, w.nx);
          if (out_normal_y != w.ny) report_mismatch("normal_y", out_normal_y, w.ny);
          if (out_normal_z != w.nz) report_mismatch("normal_z", out_normal_z, w.nz);
          if (out_index_error != w.err)
            report_mismatch("index_error", out_index_error, w.err);
          if (w.err) err_words++;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and backs up
  initial begin
    hold_off = 0;
    wait (sent_words >= 300);
    @(posedge clk);
    hold_off <= 1;
    repeat (400) @(posedge clk);
    hold_off <= 0;
  end

  initial begin
    #8000000;
    $display("sphere_vertex_generator verification failed");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, logic [svg_pkg::RAD_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      svg_pkg::REG_RADIUS: radius_sh = data;
      svg_pkg::REG_LAT_STEPS: lat_steps_sh = data & 16'h07FF;
      svg_pkg::REG_LON_STEPS: lon_steps_sh = data & 16'h07FF;
      default: ;
    endcase
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_sphere(logic [svg_pkg::RAD_W-1:0] r, logic [svg_pkg::RAD_W-1:0] la,
                            logic [svg_pkg::RAD_W-1:0] lo);
    write_reg(svg_pkg::REG_RADIUS, r);
    write_reg(svg_pkg::REG_LAT_STEPS, la);
    write_reg(svg_pkg::REG_LON_STEPS, lo);
    @(posedge clk);
  endtask

  task automatic push_pair(int lat, int lon);
    step_pair_t sp;
    sp.lat = svg_pkg::IDX_W'(lat);
    sp.lon = svg_pkg::IDX_W'(lon);
    pending_steps.push_back(sp);
  endtask

  task automatic drain;
    do @(posedge clk);
    while (pending_steps.size() != 0 || in_valid || vertex_fifo.size() != 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic random_batch(int count);
    longint ls, ns;
    ls = clamp_steps(lat_steps_sh);
    ns = clamp_steps(lon_steps_sh);
    for (int i = 0; i < count; i++) begin
      // mostly in-range steps, some anywhere in the field
      if ($urandom_range(99) < 85 && ls > 0 && ns > 0)
        push_pair($urandom_range(ls - 1), $urandom_range(ns - 1));
      else
        push_pair($urandom_range(1023), $urandom_range(1023));
    end
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    in_valid = 0;
    in_lat_index = 0;
    in_lon_index = 0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = svg_pkg::REG_RADIUS;
    cfg_data = 0;
    radius_sh = 16;
    lat_steps_sh = 16;
    lon_steps_sh = 32;
    errors = 0;
    sent_words = 0;
    got_words = 0;
    err_words = 0;
    tx_idle = 14;
    rx_idle = 81;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings: poles, equator, seam, out-of-range steps
    push_pair(0, 0);   push_pair(15, 31); push_pair(8, 0);  push_pair(8, 8);
    push_pair(8, 16);  push_pair(8, 24);  push_pair(4, 5);  push_pair(16, 0);
    push_pair(0, 32);  push_pair(1023, 1023);
    drain();
    set_sphere(16'hFFFF, 16'd1024, 16'd1024);
    push_pair(1023, 1023); push_pair(512, 256); push_pair(512, 768);
    push_pair(341, 682);   push_pair(0, 1023);
    drain();
    set_sphere(16'd0, 16'd2047, 16'd3);
    push_pair(1023, 2); push_pair(100, 1); push_pair(5, 3);
    drain();
    set_sphere(16'd1, 16'd0, 16'd1);
    push_pair(0, 0); push_pair(1, 0);
    drain();
    set_sphere(16'd800, 16'd1, 16'd1);
    write_reg(REG_SPARE, 16'h1234);
    push_pair(0, 0); push_pair(0, 1); push_pair(1, 0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      tx_idle = (ph < 4) ? 14 : (ph < 8) ? 81 : 0;
      rx_idle = (ph < 4) ? 81 : (ph < 8) ? 14 : 0;
      if (ph % 4 == 0)
        set_sphere(16'hFFFF, 16'd1024, 16'd1024);
      else if (ph == 5)
        set_sphere(16'd0, 16'hF800 | 16'($urandom_range(1, 1024)), 16'd2047);
      else
        set_sphere(16'($urandom_range(1, 65535)), 16'hF800 | 16'($urandom_range(1, 1024)),
                   16'h7800 | 16'($urandom_range(1, 1024)));
      random_batch(160);
      drain();
    end

    $display("covered %0d vertices (%0d out of range) over 17 register settings,",
             got_words, err_words);
    $display("with sender and receiver stalls and a long output hold-off");
    if (errors == 0)
      $display("sphere_vertex_generator verification clean");
    else
      $display("sphere_vertex_generator verification failed");
    $finish;
  end

endmodule
